>>> design/hgbp_pkg.sv
// ----------------------------------------------------------------------------
// hgbp_pkg: shared types and helpers for the tournament branch predictor
// Transfer payloads, table geometry defaults and the 2-bit counter update.
// ----------------------------------------------------------------------------
`default_nettype none

package hgbp_pkg;

  // Default table geometry
  localparam int CHOOSER_INDEX_BITS_DEF = 10;
  localparam int GSHARE_INDEX_BITS_DEF  = 12;
  localparam int HISTORY_BITS_DEF       = 8;
  localparam int BIMODAL_INDEX_BITS_DEF = 12;

  // Field widths
  localparam int ADDR_W  = 32;
  localparam int COUNT_W = 32;
  localparam int PC_W    = ADDR_W - 2;
  localparam int CTR_W   = 2;

  // Counter values
  localparam logic [CTR_W-1:0] CTR_MAX          = 2'd3;
  localparam logic [CTR_W-1:0] CTR_MIN          = 2'd0;
  localparam logic [CTR_W-1:0] CTR_WEAK_TAKEN   = 2'd2;
  localparam logic [CTR_W-1:0] CHS_WEAK_BIMODAL = 2'd1;

  typedef struct packed {
    logic [ADDR_W-1:0] branch_address;
    logic              taken;
  } branch_t;

  typedef struct packed {
    logic               predicted_taken;
    logic               used_gshare;
    logic               mispredicted;
    logic [COUNT_W-1:0] prediction_count;
    logic [COUNT_W-1:0] misprediction_count;
  } result_t;

  // Saturating 2-bit counter step toward taken (up) or not taken
  function automatic logic [CTR_W-1:0] ctr_train(input logic [CTR_W-1:0] c,
                                                 input logic up);
    logic [CTR_W-1:0] r;
    if (up) begin
      r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    end else begin
      r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/hgbp_ctr_table.sv
// ----------------------------------------------------------------------------
// hgbp_ctr_table: table of 2-bit counters with registered read
// One write port and one read port; a write landing on the same edge as a
// read of the same entry is forwarded to the read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hgbp_ctr_table #(
  parameter int IDX_BITS = hgbp_pkg::BIMODAL_INDEX_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [IDX_BITS-1:0]        rd_addr,
  output logic [hgbp_pkg::CTR_W-1:0]      rd_data,
  input  wire logic                       wr_en,
  input  wire logic [IDX_BITS-1:0]        wr_addr,
  input  wire logic [hgbp_pkg::CTR_W-1:0] wr_data
);

  localparam int DEPTH = 1 << IDX_BITS;

  logic [hgbp_pkg::CTR_W-1:0] mem [DEPTH];
  logic [hgbp_pkg::CTR_W-1:0] ram_q;
  logic [IDX_BITS-1:0]        rd_addr_q;
  logic                       fwd_v;
  logic [IDX_BITS-1:0]        fwd_addr;
  logic [hgbp_pkg::CTR_W-1:0] fwd_data;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    ram_q     <= mem[rd_addr];
    rd_addr_q <= rd_addr;
  end

  // Remember the write made on the read edge
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_v <= 1'b0;
    end else begin
      fwd_v <= wr_en;
    end
    fwd_addr <= wr_addr;
    fwd_data <= wr_data;
  end

  // Forward that write over the stale array value
  assign rd_data = (fwd_v && (fwd_addr == rd_addr_q)) ? fwd_data : ram_q;

endmodule

`default_nettype wire

>>> design/hybrid_gshare_bimodal_predictor_core.sv
// ----------------------------------------------------------------------------
// hybrid_gshare_bimodal_predictor_core: tournament predictor, gshare/bimodal
// Trains on resolved branches and reports the prediction it would have made.
// ----------------------------------------------------------------------------
// Usage:
//   Branch channel (br_valid/br_stall/br) carries one resolved branch per
//   transfer: its byte address and its outcome. Result channel
//   (res_valid/res_stall/res) returns one result per branch, in order: the
//   chosen prediction, which predictor was chosen, the mispredict flag and
//   the saturating branch and mispredict totals.
//   The table reads and the update stage register on the branch transfer
//   edge; the trained result is then registered into the output buffer,
//   whose head entry drives res_valid.
//   Throughput is one branch per cycle while br_stall is low; back-to-back
//   updates to the same table entry are forwarded around the table's registered read port.
//   After reset the block sweeps all three tables to their initial values,
//   one entry per table per cycle; br_stall is high during the sweep.
//   A stalled result is held in a two-entry output buffer; outside the sweep,
//   br_stall rises only when that buffer would otherwise overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module hybrid_gshare_bimodal_predictor_core #(
  parameter int CHOOSER_INDEX_BITS = hgbp_pkg::CHOOSER_INDEX_BITS_DEF,
  parameter int GSHARE_INDEX_BITS  = hgbp_pkg::GSHARE_INDEX_BITS_DEF,
  parameter int HISTORY_BITS       = hgbp_pkg::HISTORY_BITS_DEF,
  parameter int BIMODAL_INDEX_BITS = hgbp_pkg::BIMODAL_INDEX_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              br_valid,
  output logic                   br_stall,
  input  wire hgbp_pkg::branch_t br,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output hgbp_pkg::result_t      res
);

  localparam int MAX_AB   = (BIMODAL_INDEX_BITS > GSHARE_INDEX_BITS) ?
                            BIMODAL_INDEX_BITS : GSHARE_INDEX_BITS;
  localparam int CLR_BITS = (MAX_AB > CHOOSER_INDEX_BITS) ? MAX_AB : CHOOSER_INDEX_BITS;

  // Clear sweep
  logic                clr_active;
  logic [CLR_BITS-1:0] clr_idx;

  // Front end
  logic                         br_fire;
  logic [hgbp_pkg::PC_W-1:0]    pc;
  logic [BIMODAL_INDEX_BITS-1:0] bim_idx;
  logic [GSHARE_INDEX_BITS-1:0]  gsh_idx;
  logic [GSHARE_INDEX_BITS-1:0]  hist_term;
  logic [CHOOSER_INDEX_BITS-1:0] chs_idx;
  logic [HISTORY_BITS-1:0]       hist;
  logic [HISTORY_BITS-1:0]       hist_next;

  // Update stage
  logic                          s1_v;
  logic                          s1_taken;
  logic [BIMODAL_INDEX_BITS-1:0] s1_bim_idx;
  logic [GSHARE_INDEX_BITS-1:0]  s1_gsh_idx;
  logic [CHOOSER_INDEX_BITS-1:0] s1_chs_idx;
  logic [hgbp_pkg::CTR_W-1:0]    bim_rd;
  logic [hgbp_pkg::CTR_W-1:0]    gsh_rd;
  logic [hgbp_pkg::CTR_W-1:0]    chs_rd;
  logic                          use_g;
  logic                          pred_g;
  logic                          pred_b;
  logic                          pred;
  logic                          miss;

  // Table write ports
  logic                          bim_we;
  logic [BIMODAL_INDEX_BITS-1:0] bim_wa;
  logic [hgbp_pkg::CTR_W-1:0]    bim_wd;
  logic                          gsh_we;
  logic [GSHARE_INDEX_BITS-1:0]  gsh_wa;
  logic [hgbp_pkg::CTR_W-1:0]    gsh_wd;
  logic                          chs_we;
  logic [CHOOSER_INDEX_BITS-1:0] chs_wa;
  logic [hgbp_pkg::CTR_W-1:0]    chs_wd;

  // Totals
  logic [hgbp_pkg::COUNT_W-1:0] branch_total;
  logic [hgbp_pkg::COUNT_W-1:0] branch_total_next;
  logic [hgbp_pkg::COUNT_W-1:0] miss_total;
  logic [hgbp_pkg::COUNT_W-1:0] miss_total_next;
  hgbp_pkg::result_t            s1_res;

  // Output buffer
  logic              head_v;
  logic              skid_v;
  hgbp_pkg::result_t head;
  hgbp_pkg::result_t skid;
  logic              res_fire;
  logic [1:0]        occupancy;

  // ---------------------------------------------------------------------------
  // Clear sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_idx    <= '0;
    end else if (clr_active) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == {CLR_BITS{1'b1}}) begin
        clr_active <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Accept rule: the transfer must find room in the output buffer later
  assign res_fire  = head_v & ~res_stall;
  assign occupancy = {1'b0, head_v} + {1'b0, skid_v} + {1'b0, s1_v} - {1'b0, res_fire};
  assign br_stall  = clr_active | (occupancy > 2'd1);
  assign br_fire   = br_valid & ~br_stall;

  // Table indexes
  assign pc      = br.branch_address[hgbp_pkg::ADDR_W-1:2];
  assign bim_idx = pc[BIMODAL_INDEX_BITS-1:0];
  assign chs_idx = pc[CHOOSER_INDEX_BITS-1:0];

  generate
    if (HISTORY_BITS <= GSHARE_INDEX_BITS) begin : g_hist_short
      assign hist_term = GSHARE_INDEX_BITS'(hist) << (GSHARE_INDEX_BITS - HISTORY_BITS);
    end else begin : g_hist_long
      assign hist_term = hist[HISTORY_BITS-1 -: GSHARE_INDEX_BITS];
    end
  endgenerate

  assign gsh_idx = pc[GSHARE_INDEX_BITS-1:0] ^ hist_term;

  // Shift the outcome in at the top of the history
  always_comb begin
    hist_next                 = hist >> 1;
    hist_next[HISTORY_BITS-1] = br.taken;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (br_fire) begin
      hist <= hist_next;
    end
  end

  // Advance into the update stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= br_fire;
    end
    s1_taken   <= br.taken;
    s1_bim_idx <= bim_idx;
    s1_gsh_idx <= gsh_idx;
    s1_chs_idx <= chs_idx;
  end

  // ---------------------------------------------------------------------------
  // Counter tables
  hgbp_ctr_table #(.IDX_BITS(BIMODAL_INDEX_BITS)) u_bim (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (bim_idx),
    .rd_data (bim_rd),
    .wr_en   (bim_we),
    .wr_addr (bim_wa),
    .wr_data (bim_wd)
  );

  hgbp_ctr_table #(.IDX_BITS(GSHARE_INDEX_BITS)) u_gsh (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (gsh_idx),
    .rd_data (gsh_rd),
    .wr_en   (gsh_we),
    .wr_addr (gsh_wa),
    .wr_data (gsh_wd)
  );

  hgbp_ctr_table #(.IDX_BITS(CHOOSER_INDEX_BITS)) u_chs (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (chs_idx),
    .rd_data (chs_rd),
    .wr_en   (chs_we),
    .wr_addr (chs_wa),
    .wr_data (chs_wd)
  );

  // ---------------------------------------------------------------------------
  // Predict and train
  assign use_g  = chs_rd[1];
  assign pred_g = gsh_rd[1];
  assign pred_b = bim_rd[1];
  assign pred   = use_g ? pred_g : pred_b;
  assign miss   = pred ^ s1_taken;

  // Write back the trained counters, or the reset values while sweeping
  always_comb begin
    if (clr_active) begin
      bim_we = 1'b1;
      bim_wa = clr_idx[BIMODAL_INDEX_BITS-1:0];
      bim_wd = hgbp_pkg::CTR_WEAK_TAKEN;
      gsh_we = 1'b1;
      gsh_wa = clr_idx[GSHARE_INDEX_BITS-1:0];
      gsh_wd = hgbp_pkg::CTR_WEAK_TAKEN;
      chs_we = 1'b1;
      chs_wa = clr_idx[CHOOSER_INDEX_BITS-1:0];
      chs_wd = hgbp_pkg::CHS_WEAK_BIMODAL;
    end else begin
      bim_we = s1_v & ~use_g;
      bim_wa = s1_bim_idx;
      bim_wd = hgbp_pkg::ctr_train(bim_rd, s1_taken);
      gsh_we = s1_v & use_g;
      gsh_wa = s1_gsh_idx;
      gsh_wd = hgbp_pkg::ctr_train(gsh_rd, s1_taken);
      chs_we = s1_v & (pred_g ^ pred_b);
      chs_wa = s1_chs_idx;
      chs_wd = hgbp_pkg::ctr_train(chs_rd, pred_g == s1_taken);
    end
  end

  // Saturating totals
  assign branch_total_next = (branch_total == {hgbp_pkg::COUNT_W{1'b1}}) ?
                             branch_total : branch_total + 1'b1;
  assign miss_total_next   = (!miss || miss_total == {hgbp_pkg::COUNT_W{1'b1}}) ?
                             miss_total : miss_total + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      branch_total <= '0;
      miss_total   <= '0;
    end else if (s1_v) begin
      branch_total <= branch_total_next;
      miss_total   <= miss_total_next;
    end
  end

  always_comb begin
    s1_res.predicted_taken     = pred;
    s1_res.used_gshare         = use_g;
    s1_res.mispredicted        = miss;
    s1_res.prediction_count    = branch_total_next;
    s1_res.misprediction_count = miss_total_next;
  end

  // ---------------------------------------------------------------------------
  // Output buffer: head drives the port, skid catches a result under stall
  always_ff @(posedge clk) begin
    if (rst) begin
      head_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (res_fire) begin
      if (skid_v) begin
        head_v <= 1'b1;
        skid_v <= s1_v;
      end else begin
        head_v <= s1_v;
      end
    end else if (s1_v) begin
      if (!head_v) begin
        head_v <= 1'b1;
      end else begin
        skid_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      if (skid_v) begin
        head <= skid;
        skid <= s1_res;
      end else begin
        head <= s1_res;
      end
    end else if (s1_v) begin
      if (!head_v) begin
        head <= s1_res;
      end else begin
        skid <= s1_res;
      end
    end
  end

  assign res_valid = head_v;
  assign res       = head;

  // ---------------------------------------------------------------------------
  // Assertions
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> br_stall)
    else $error("branch transfer accepted during table sweep");

  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> head_v)
    else $error("skid entry held without a head entry");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (s1_v && skid_v) |-> res_fire)
    else $error("update stage result has no buffer room");

  a_stage_follows_accept: assert property (@(posedge clk) disable iff (rst)
    s1_v |-> $past(br_fire))
    else $error("update stage active without an accepted branch");

  a_miss_le_total: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.misprediction_count <= res.prediction_count))
    else $error("mispredict total exceeds branch total");

endmodule

`default_nettype wire

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Tournament branch predictor testbench
// Streams resolved branches into the predictor core and checks every result
// against a local gshare/bimodal/chooser model. It runs under several idle
// and stall mixes, plus one long receiver hold that backs the core up.
// ----------------------------------------------------------------------------

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hgbp_pkg::*;

  // Geometry under test
  localparam int CHS_BITS  = CHOOSER_INDEX_BITS_DEF;
  localparam int GSH_BITS  = GSHARE_INDEX_BITS_DEF;
  localparam int HIST_BITS = HISTORY_BITS_DEF;
  localparam int BIM_BITS  = BIMODAL_INDEX_BITS_DEF;

  localparam int RESET_CYCLES  = 9;
  localparam int HOLD_CYCLES   = 60;
  localparam int TAIL_CYCLES   = 12;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int HOT_BRANCHES  = 16;
  localparam int PHASE_ITEMS   = 220;
  localparam int PRESSURE_ITEMS = 70;

  // Outcome patterns of the hot branches in the synthetic trace
  typedef enum int {
    PAT_ALWAYS, PAT_NEVER, PAT_LOOP, PAT_ALTERNATE, PAT_FOLLOW, PAT_RANDOM
  } pattern_e;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    br_valid = 1'b0;
  logic    br_stall;
  branch_t br = '0;
  logic    res_valid;
  logic    res_stall = 1'b0;
  result_t res;

  // Predictor state mirror
  logic [1:0]  bim_ctr [1 << BIM_BITS];
  logic [1:0]  gsh_ctr [1 << GSH_BITS];
  logic [1:0]  chs_ctr [1 << CHS_BITS];
  int unsigned path_hist;
  logic [31:0] seen_count;
  logic [31:0] miss_count;

  branch_t     branch_trace[$];
  result_t     predicted_results[$];
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  bit          br_accepted = 1'b0;
  int unsigned cycle_count = 0;

  // Synthetic program: hot branches with their behavior
  logic [31:0] hot_addr [HOT_BRANCHES];
  pattern_e    hot_kind [HOT_BRANCHES];
  int          hot_period [HOT_BRANCHES];
  int          hot_iter [HOT_BRANCHES];
  logic        last_outcome = 1'b0;

  hybrid_gshare_bimodal_predictor_core #(
    .CHOOSER_INDEX_BITS(CHS_BITS),
    .GSHARE_INDEX_BITS (GSH_BITS),
    .HISTORY_BITS      (HIST_BITS),
    .BIMODAL_INDEX_BITS(BIM_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .br_valid (br_valid),
    .br_stall (br_stall),
    .br       (br),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 0;
  end

  // Saturating 2-bit step
  function automatic logic [1:0] sat_step(logic [1:0] c, logic up);
    if (up) return (c != CTR_MAX) ? c + 2'd1 : c;
    return (c != CTR_MIN) ? c - 2'd1 : c;
  endfunction

  task automatic clear_predictor();
    foreach (bim_ctr[i]) bim_ctr[i] = CTR_WEAK_TAKEN;
    foreach (gsh_ctr[i]) gsh_ctr[i] = CTR_WEAK_TAKEN;
    foreach (chs_ctr[i]) chs_ctr[i] = CHS_WEAK_BIMODAL;
    path_hist  = 0;
    seen_count = '0;
    miss_count = '0;
  endtask

  // Predict one resolved branch and train the mirror
  task automatic predict_branch(input branch_t b, output result_t r);
    int unsigned pc, bi, gi, ci;
    logic        pick_g, g_says, b_says, guess, miss;
    pc = b.branch_address >> 2;
    bi = pc & ((32'd1 << BIM_BITS) - 1);
    ci = pc & ((32'd1 << CHS_BITS) - 1);
    gi = pc & ((32'd1 << GSH_BITS) - 1);
    // Fold history into the top of the gshare index; a longer history
    // loses its low bits
    if (HIST_BITS <= GSH_BITS) gi ^= path_hist << (GSH_BITS - HIST_BITS);
    else gi ^= path_hist >> (HIST_BITS - GSH_BITS);
    gi &= (32'd1 << GSH_BITS) - 1;

    pick_g = chs_ctr[ci] >= CTR_WEAK_TAKEN;
    g_says = gsh_ctr[gi] >= CTR_WEAK_TAKEN;
    b_says = bim_ctr[bi] >= CTR_WEAK_TAKEN;
    guess  = pick_g ? g_says : b_says;
    miss   = guess != b.taken;

    // Train only the chosen side; move the chooser when the two disagree
    if (pick_g) gsh_ctr[gi] = sat_step(gsh_ctr[gi], b.taken);
    else bim_ctr[bi] = sat_step(bim_ctr[bi], b.taken);
    if (g_says != b_says) chs_ctr[ci] = sat_step(chs_ctr[ci], g_says == b.taken);

    path_hist = ((path_hist >> 1) | (b.taken ? (32'd1 << (HIST_BITS - 1)) : 0))
                & ((32'd1 << HIST_BITS) - 1);
    if (seen_count != '1) seen_count++;
    if (miss && miss_count != '1) miss_count++;

    r.predicted_taken     = guess;
    r.used_gshare         = pick_g;
    r.mispredicted        = miss;
    r.prediction_count    = seen_count;
    r.misprediction_count = miss_count;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic add_branch(input logic [31:0] addr, input logic t);
    branch_t b;
    b.branch_address = addr;
    b.taken          = t;
    branch_trace.push_back(b);
  endtask

  // Loop over a body of hot branches, with some random noise mixed in
  task automatic add_trace(input int count, input int body_len);
    int base, pos, k;
    logic t;
    base = $urandom_range(0, HOT_BRANCHES - 1);
    pos  = 0;
    repeat (count) begin
      if ($urandom_range(0, 99) < 12) begin
        add_branch($urandom(), $urandom_range(0, 1));
      end else begin
        k = (base + pos) % HOT_BRANCHES;
        pos = (pos + 1) % body_len;
        case (hot_kind[k])
          PAT_ALWAYS:    t = 1'b1;
          PAT_NEVER:     t = 1'b0;
          PAT_LOOP:      t = (hot_iter[k] % hot_period[k]) != hot_period[k] - 1;
          PAT_ALTERNATE: t = hot_iter[k][0];
          PAT_FOLLOW:    t = last_outcome;
          default:       t = $urandom_range(0, 1);
        endcase
        hot_iter[k]++;
        last_outcome = t;
        add_branch(hot_addr[k], t);
      end
    end
  endtask

  task automatic wait_drained();
    while (branch_trace.size() != 0 || br_valid || predicted_results.size() != 0)
      @(negedge clk);
  endtask

  // Sender: hold the payload until its transfer, then advance or idle
  always @(negedge clk) begin : sender
    if (rst) begin
      br_valid <= 1'b0;
    end else if (!br_valid || br_accepted) begin
      br_accepted = 1'b0;
      if (branch_trace.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        br       <= branch_trace.pop_front();
        br_valid <= 1'b1;
      end else begin
        br_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall, or a long hold when requested
  always @(negedge clk) begin : receiver
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= $urandom_range(0, 99) < stall_pct;
    end
  end

  // Monitor: predict on each branch transfer, check each result transfer
  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst) begin
      if (br_valid && !br_stall) begin
        predict_branch(br, want);
        predicted_results.push_back(want);
        br_accepted = 1'b1;
      end
      if (res_valid && !res_stall) begin
        if (predicted_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result: expected none, actual %p", $time, res);
        end else begin
          want = predicted_results.pop_front();
          check_field("predicted_taken", want.predicted_taken, res.predicted_taken);
          check_field("used_gshare", want.used_gshare, res.used_gshare);
          check_field("mispredicted", want.mispredicted, res.mispredicted);
          check_field("prediction_count", want.prediction_count, res.prediction_count);
          check_field("misprediction_count", want.misprediction_count,
                      res.misprediction_count);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    int send_tab [4];
    int stall_tab [4];
    send_tab  = '{0, 78, 0, 29};
    stall_tab = '{0, 0, 78, 29};

    clear_predictor();
    for (int i = 0; i < HOT_BRANCHES; i++) begin
      // The last few alias an earlier branch in the bimodal and chooser tables
      if (i >= HOT_BRANCHES - 4)
        hot_addr[i] = hot_addr[i - 8] ^ (32'd1 << $urandom_range(14, 31));
      else
        hot_addr[i] = $urandom();
      hot_kind[i]   = pattern_e'($urandom_range(PAT_ALWAYS, PAT_RANDOM));
      hot_period[i] = $urandom_range(2, 7);
      hot_iter[i]   = 0;
    end

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Directed: address extremes, aliasing and counter saturation both ways
    add_branch(32'h0000_0000, 1'b0);
    add_branch(32'hFFFF_FFFF, 1'b1);
    add_branch(32'hFFFF_FFFC, 1'b0);
    add_branch(32'h0000_0003, 1'b1);
    add_branch(32'hAAAA_AAAA, 1'b1);
    add_branch(32'h5555_5555, 1'b0);
    add_branch(32'h8000_4000, 1'b1);
    add_branch(32'h0000_4000, 1'b0);
    repeat (4) add_branch(32'h0000_1000, 1'b1);
    repeat (5) add_branch(32'h0000_1000, 1'b0);
    repeat (2) add_branch(32'h0000_2000, 1'b0);
    repeat (2) add_branch(32'h0000_2000, 1'b1);
    add_branch(32'h7FFF_FFFF, 1'b1);
    add_branch(32'h8000_0000, 1'b0);
    wait_drained();

    // Random traces under each idle and stall mix
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_tab[p];
      stall_pct     = stall_tab[p];
      add_trace(PHASE_ITEMS, $urandom_range(2, 12));
      wait_drained();
    end

    // Back the core up: long receiver hold with the sender at full rate
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b1;
    add_trace(PRESSURE_ITEMS, $urandom_range(2, 12));
    wait_drained();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (predicted_results.size() != 0) begin
      error_count++;
      $display("%0t: %0d results expected, none arrived", $time, predicted_results.size());
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
